### rtl/core/dbe_pkg.sv
`timescale 1ns / 1ps
package dbe_pkg;

    localparam int MAX_DEGREE_DEF = 15;
    localparam int DEG_N          = 16;   // entries of the per-degree tables (4-bit index)

    localparam logic signed [63:0] FRAC_ONE = 64'sh0000_0000_4000_0000;
    localparam logic signed [63:0] SAT_POS  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_MAX  = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_MIN  = -65'sh0_7FFF_FFFF_FFFF_FFFF;

    // work item handed from the front to the back
    typedef struct packed {
        logic signed [63:0] u;
        logic signed [63:0] s;
        logic signed [31:0] y;
        logic        [3:0]  p;
        logic        [3:0]  q;
    } t_job;

    typedef struct packed {
        logic start;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic done;
        logic signed [63:0] prod;
    } t_mul_rsp;

    typedef enum logic [3:0] {
        ST_IDLE, ST_V, ST_L1, ST_L2, ST_L3, ST_L4, ST_JI,
        ST_J1, ST_J2, ST_J3, ST_F1, ST_F2, ST_OUT
    } t_state;

    // saturating sum to +-(2^63 - 1)
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] sum;
        sum = {a[63], a} + {b[63], b};
        if (sum > SUM_MAX) return SAT_POS;
        else if (sum < SUM_MIN) return -SAT_POS;
        else return sum[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        return sat_add(a, -b);
    endfunction

    // sqrt((2p+1)(p+q+1)/2) in Q.30, from a rounded integer root in Q.24
    function automatic logic [63:0] weight(input int p, input int q);
        logic [63:0] nn;
        logic [63:0] rem;
        logic [63:0] r;
        logic [63:0] b;
        nn  = 64'((2 * p + 1) * (p + q + 1)) << 47;
        rem = nn;
        r   = '0;
        for (int i = 0; i < 32; i++) begin
            b = 64'd1 << (62 - 2 * i);
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        if (nn - r * r > r) r = r + 64'd1;
        return r << 6;
    endfunction

endpackage

### rtl/core/dbe_in_if.sv
`timescale 1ns / 1ps
interface dbe_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic        [3:0]  p_degree;
    logic        [3:0]  q_degree;

    modport source (output valid, x_coord, y_coord, p_degree, q_degree, input ready);
    modport sink   (input valid, x_coord, y_coord, p_degree, q_degree, output ready);
endinterface

### rtl/core/dbe_out_if.sv
`timescale 1ns / 1ps
interface dbe_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] basis_value;
    logic               saturated;

    modport source (output valid, basis_value, saturated, input ready);
    modport sink   (input valid, basis_value, saturated, output ready);
endinterface

### rtl/core/dubiner_basis_eval.sv
`timescale 1ns / 1ps
// Evaluates one orthonormal Dubiner triangle basis function psi_pq at a point
// (x, y), both Q2.30, giving a Q8.24 value rounded and saturated with a flag.
// p and q above MAX_DEGREE are clipped. Each 64x64 product on the one shared
// multiplier runs a request, four 32x32 partial products, rounding, and the
// hand-back of the result. An item needs 1 + 4p + 3q + 2 products plus the
// control states ST_IDLE, ST_JI and ST_OUT.
// The front maps the point and queues up to two items, so inputs keep being
// taken while the back works and while a finished item waits on the output.
module dubiner_basis_eval #(
    parameter int MAX_DEGREE = dbe_pkg::MAX_DEGREE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dbe_in_if.sink    i_in,
    dbe_out_if.source o_out
);
    // front to queue
    logic          w_push;
    logic          w_full;
    dbe_pkg::t_job w_fjob;
    // queue to back
    logic          w_pop;
    logic          w_qvalid;
    dbe_pkg::t_job w_qjob;

    // point mapping, top vertex handling and degree clipping
    dbe_front #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_front (
        .i_in     (i_in),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_job    (w_fjob)
    );

    // two-entry item queue between front and back
    dbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_job   (w_qjob)
    );

    // recurrence sequencer with shared multiplier and output register
    dbe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_qvalid),
        .i_job     (w_qjob),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );
endmodule

### rtl/core/dbe_front.sv
`timescale 1ns / 1ps
module dbe_front #(
    parameter int MAX_DEGREE = dbe_pkg::MAX_DEGREE_DEF
) (
    dbe_in_if.sink          i_in,
    input  logic            i_q_full,
    output logic            o_push,
    output dbe_pkg::t_job   o_job
);
    logic signed [33:0] w_d;
    logic signed [63:0] w_s;
    logic signed [63:0] w_xp;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        // s = floor((1 - y) / 2) in raw units
        w_d  = 34'sh0_4000_0000 - {{2{i_in.y_coord[31]}}, i_in.y_coord};
        w_s  = $signed({{30{w_d[33]}}, w_d}) >>> 1;
        w_xp = dbe_pkg::FRAC_ONE + {{32{i_in.x_coord[31]}}, i_in.x_coord};
        o_job.s = w_s;
        o_job.y = i_in.y_coord;
        // top vertex: eta1 forced to -1
        if (i_in.y_coord < 32'sh4000_0000) o_job.u = dbe_pkg::sat_sub(w_xp, w_s);
        else o_job.u = -w_s;
        if (32'(i_in.p_degree) > MAX_DEGREE) o_job.p = 4'(MAX_DEGREE);
        else o_job.p = i_in.p_degree;
        if (32'(i_in.q_degree) > MAX_DEGREE) o_job.q = 4'(MAX_DEGREE);
        else o_job.q = i_in.q_degree;
    end
endmodule

### rtl/core/dbe_queue.sv
`timescale 1ns / 1ps
module dbe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dbe_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output dbe_pkg::t_job o_job
);
    dbe_pkg::t_job r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("queue count out of range");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != 2'd0) else $error("pop from empty queue");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count != 2'd2) else $error("push into full queue");
endmodule

### rtl/core/dbe_mul.sv
`timescale 1ns / 1ps
module dbe_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dbe_pkg::t_mul_req i_req,
    output dbe_pkg::t_mul_rsp o_rsp
);
    logic         r_busy;
    logic         r_fin;
    logic [1:0]   r_cnt;
    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic         r_neg;
    logic [127:0] r_acc;
    logic         r_done;
    logic signed [63:0] r_prod;

    logic [31:0]  w_pa;
    logic [31:0]  w_pb;
    logic [63:0]  w_pp;
    logic [127:0] w_sh;
    logic [63:0]  w_mag;

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_prod;

    // one 32x32 partial product per cycle
    always_comb begin
        w_pa = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
        w_pb = (r_cnt == 2'd1 || r_cnt == 2'd3) ? r_mb[63:32] : r_mb[31:0];
        w_pp = 64'(w_pa) * 64'(w_pb);
        case (r_cnt)
            2'd0:    w_sh = {64'd0, w_pp};
            2'd3:    w_sh = {w_pp, 64'd0};
            default: w_sh = {32'd0, w_pp, 32'd0};
        endcase
        if (|r_acc[127:93]) w_mag = dbe_pkg::SAT_POS;
        else w_mag = {1'b0, r_acc[92:30]};
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_ma  <= i_req.a[63] ? 64'(-i_req.a) : 64'(i_req.a);
            r_mb  <= i_req.b[63] ? 64'(-i_req.b) : 64'(i_req.b);
            r_neg <= i_req.a[63] ^ i_req.b[63];
            r_acc <= 128'd1 << 29;
        end else if (r_busy) begin
            r_acc <= r_acc + w_sh;
        end
        if (r_fin) r_prod <= r_neg ? -$signed(w_mag) : $signed(w_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= r_busy && (r_cnt == 2'd3);
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) r_busy <= 1'b0;
            end
        end
    end
endmodule

### rtl/core/dbe_back.sv
`timescale 1ns / 1ps
module dbe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  dbe_pkg::t_job i_job,
    output logic          o_pop,
    dbe_out_if.source     o_out
);
    // recurrence coefficient tables, worked out at elaboration
    logic signed [63:0] w_lb [dbe_pkg::DEG_N];
    logic signed [63:0] w_lc [dbe_pkg::DEG_N];
    logic signed [63:0] w_ja [dbe_pkg::DEG_N][dbe_pkg::DEG_N];
    logic signed [63:0] w_jb [dbe_pkg::DEG_N][dbe_pkg::DEG_N];
    logic signed [63:0] w_jc [dbe_pkg::DEG_N][dbe_pkg::DEG_N];
    logic signed [63:0] w_w  [dbe_pkg::DEG_N][dbe_pkg::DEG_N];

    for (genvar gp = 0; gp < dbe_pkg::DEG_N; gp++) begin : g_p
        localparam longint NL = (gp == 0) ? 1 : gp;
        localparam longint LB = (((2 * NL - 1) << 30) + (NL >> 1)) / NL;
        localparam longint LC = (((NL - 1) << 30) + (NL >> 1)) / NL;
        assign w_lb[gp] = (gp == 0) ? 64'sd0 : 64'(LB);
        assign w_lc[gp] = (gp == 0) ? 64'sd0 : 64'(LC);
        for (genvar gn = 0; gn < dbe_pkg::DEG_N; gn++) begin : g_n
            localparam longint AL = 2 * gp + 1;
            localparam longint NN = (gn == 0) ? 1 : gn;
            localparam longint TT = 2 * (NN - 1) + AL;
            localparam longint A1 = 2 * NN * (NN + AL) * TT;
            localparam longint A2 = (TT + 1) * AL * AL;
            localparam longint A3 = TT * (TT + 1) * (TT + 2);
            localparam longint A4 = 2 * (NN - 1 + AL) * (NN - 1) * (TT + 2);
            localparam longint CA = ((A2 << 30) + (A1 >> 1)) / A1;
            localparam longint CB = ((A3 << 30) + (A1 >> 1)) / A1;
            localparam longint CC = ((A4 << 30) + (A1 >> 1)) / A1;
            assign w_ja[gp][gn] = 64'(CA);
            assign w_jb[gp][gn] = 64'(CB);
            assign w_jc[gp][gn] = 64'(CC);
            assign w_w[gp][gn]  = dbe_pkg::weight(gp, gn);
        end
    end

    dbe_pkg::t_state    r_state, n_state;
    dbe_pkg::t_job      r_job, n_job;
    logic               r_issued, n_issued;
    logic [3:0]         r_n, n_n;
    logic signed [63:0] r_v, n_v;
    logic signed [63:0] r_p1, n_p1;
    logic signed [63:0] r_p2, n_p2;
    logic signed [63:0] r_t, n_t;
    logic signed [63:0] r_t2, n_t2;
    logic signed [63:0] r_lq, n_lq;
    logic               r_ov, n_ov;
    logic signed [31:0] r_oval, n_oval;
    logic               r_osat, n_osat;

    dbe_pkg::t_mul_req  w_req;
    dbe_pkg::t_mul_rsp  w_rsp;
    logic               w_mstate;
    logic signed [63:0] w_res;
    logic [63:0]        w_mag;
    logic [63:0]        w_mo;
    logic [63:0]        w_lim;

    dbe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_out.valid       = r_ov;
    assign o_out.basis_value = r_oval;
    assign o_out.saturated   = r_osat;

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_issued = r_issued;
        n_n      = r_n;
        n_v      = r_v;
        n_p1     = r_p1;
        n_p2     = r_p2;
        n_t      = r_t;
        n_t2     = r_t2;
        n_lq     = r_lq;
        n_ov     = r_ov && !o_out.ready;
        n_oval   = r_oval;
        n_osat   = r_osat;
        o_pop    = 1'b0;
        w_req.a  = r_job.s;
        w_req.b  = r_job.s;
        w_res    = w_rsp.prod;
        w_mstate = 1'b1;
        w_mag    = r_t[63] ? 64'(-r_t) : 64'(r_t);
        w_mo     = (w_mag + 64'd32) >> 6;
        w_lim    = r_t[63] ? 64'h8000_0000 : 64'h7FFF_FFFF;

        case (r_state)
            dbe_pkg::ST_IDLE: begin
                w_mstate = 1'b0;
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_p1    = dbe_pkg::FRAC_ONE;
                    n_p2    = '0;
                    n_n     = 4'd1;
                    n_state = dbe_pkg::ST_V;
                end
            end
            dbe_pkg::ST_V: begin
                if (w_rsp.done) begin
                    n_v     = w_res;
                    n_state = (r_job.p != 4'd0) ? dbe_pkg::ST_L1 : dbe_pkg::ST_JI;
                end
            end
            dbe_pkg::ST_L1: begin
                w_req.a = r_job.u;
                w_req.b = r_p1;
                if (w_rsp.done) begin
                    n_t     = w_res;
                    n_state = dbe_pkg::ST_L2;
                end
            end
            dbe_pkg::ST_L2: begin
                w_req.a = w_lb[r_n];
                w_req.b = r_t;
                if (w_rsp.done) begin
                    n_t     = w_res;
                    n_state = dbe_pkg::ST_L3;
                end
            end
            dbe_pkg::ST_L3: begin
                w_req.a = r_v;
                w_req.b = r_p2;
                if (w_rsp.done) begin
                    n_t2    = w_res;
                    n_state = dbe_pkg::ST_L4;
                end
            end
            dbe_pkg::ST_L4: begin
                w_req.a = w_lc[r_n];
                w_req.b = r_t2;
                if (w_rsp.done) begin
                    n_p1 = dbe_pkg::sat_sub(r_t, w_res);
                    n_p2 = r_p1;
                    if (r_n == r_job.p) n_state = dbe_pkg::ST_JI;
                    else begin
                        n_n     = r_n + 4'd1;
                        n_state = dbe_pkg::ST_L1;
                    end
                end
            end
            dbe_pkg::ST_JI: begin
                w_mstate = 1'b0;
                n_lq     = r_p1;
                n_p1     = dbe_pkg::FRAC_ONE;
                n_p2     = '0;
                n_n      = 4'd1;
                n_state  = (r_job.q != 4'd0) ? dbe_pkg::ST_J1 : dbe_pkg::ST_F1;
            end
            dbe_pkg::ST_J1: begin
                w_req.a = w_jb[r_job.p][r_n];
                w_req.b = {{32{r_job.y[31]}}, r_job.y};
                if (w_rsp.done) begin
                    n_t     = w_res;
                    n_state = dbe_pkg::ST_J2;
                end
            end
            dbe_pkg::ST_J2: begin
                w_req.a = dbe_pkg::sat_add(w_ja[r_job.p][r_n], r_t);
                w_req.b = r_p1;
                if (w_rsp.done) begin
                    n_t     = w_res;
                    n_state = dbe_pkg::ST_J3;
                end
            end
            dbe_pkg::ST_J3: begin
                w_req.a = w_jc[r_job.p][r_n];
                w_req.b = r_p2;
                if (w_rsp.done) begin
                    n_p1 = dbe_pkg::sat_sub(r_t, w_res);
                    n_p2 = r_p1;
                    if (r_n == r_job.q) n_state = dbe_pkg::ST_F1;
                    else begin
                        n_n     = r_n + 4'd1;
                        n_state = dbe_pkg::ST_J1;
                    end
                end
            end
            dbe_pkg::ST_F1: begin
                w_req.a = r_lq;
                w_req.b = r_p1;
                if (w_rsp.done) begin
                    n_t     = w_res;
                    n_state = dbe_pkg::ST_F2;
                end
            end
            dbe_pkg::ST_F2: begin
                w_req.a = w_w[r_job.p][r_job.q];
                w_req.b = r_t;
                if (w_rsp.done) begin
                    n_t     = w_res;
                    n_state = dbe_pkg::ST_OUT;
                end
            end
            dbe_pkg::ST_OUT: begin
                w_mstate = 1'b0;
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_osat  = (w_mo > w_lim);
                    n_oval  = (w_mo > w_lim) ? (r_t[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                            : (r_t[63] ? -$signed(w_mo[31:0]) : $signed(w_mo[31:0]));
                    n_state = dbe_pkg::ST_IDLE;
                end
            end
            default: begin
                w_mstate = 1'b0;
                n_state  = dbe_pkg::ST_IDLE;
            end
        endcase

        w_req.start = w_mstate && !r_issued;
        if (w_req.start) n_issued = 1'b1;
        else if (w_rsp.done) n_issued = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_n    <= n_n;
        r_v    <= n_v;
        r_p1   <= n_p1;
        r_p2   <= n_p2;
        r_t    <= n_t;
        r_t2   <= n_t2;
        r_lq   <= n_lq;
        r_oval <= n_oval;
        r_osat <= n_osat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dbe_pkg::ST_IDLE;
            r_issued <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            r_ov     <= n_ov;
        end
    end

    a_leg_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dbe_pkg::ST_L1) |-> (r_n != 4'd0 && r_n <= r_job.p))
        else $error("legendre step index out of range");
    a_jac_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dbe_pkg::ST_J1) |-> (r_n != 4'd0 && r_n <= r_job.q))
        else $error("jacobi step index out of range");
    a_done_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_issued) else $error("product returned without request");
endmodule
